// File: hw/rtl/cpt_pkg.sv
package cpt_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  // latency of the split signed multiplier
  localparam int MUL_LAT = 4;

  // start transfer to done strobe, in cycles
  function automatic int cpt_lat(input int coord_width);
    return 8 + 3 * MUL_LAT + coord_width + 4;
  endfunction

endpackage

// File: hw/rtl/closest_point_on_triangle_core.sv
// Closest point on triangle ABC to query point P, all coordinates signed fixed point in
// COORD_WIDTH bits. A query is taken on every cycle that start is high (busy is always
// low), and its result shows on rx_o/ry_o/rz_o/on_boundary_o with done_o high for one
// cycle; the result cannot be held off. Most of the pipeline lies in the quotient unit,
// which resolves one quotient bit per stage over COORD_WIDTH+3 stages, and in three
// ranks of four-stage multipliers.
module closest_point_on_triangle_core import cpt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] ax_i,
  input  logic [COORD_WIDTH-1:0] ay_i,
  input  logic [COORD_WIDTH-1:0] az_i,
  input  logic [COORD_WIDTH-1:0] bx_i,
  input  logic [COORD_WIDTH-1:0] by_coord_i,
  input  logic [COORD_WIDTH-1:0] bz_i,
  input  logic [COORD_WIDTH-1:0] cx_i,
  input  logic [COORD_WIDTH-1:0] cy_i,
  input  logic [COORD_WIDTH-1:0] cz_i,
  input  logic [COORD_WIDTH-1:0] px_i,
  input  logic [COORD_WIDTH-1:0] py_i,
  input  logic [COORD_WIDTH-1:0] pz_i,
  output logic                   done_o,
  output logic [COORD_WIDTH-1:0] rx_o,
  output logic [COORD_WIDTH-1:0] ry_o,
  output logic [COORD_WIDTH-1:0] rz_o,
  output logic                   on_boundary_o
);

  localparam int W    = COORD_WIDTH;
  localparam int VEC  = W + 1;
  localparam int PW   = 2 * VEC;
  localparam int DW   = 2 * W + 4;
  localparam int EW   = DW + 1;
  localparam int VW   = 2 * DW + 1;
  localparam int DENW = VW + 2;
  localparam int NPW  = VW + VEC;
  localparam int NW   = NPW + 1;
  localparam int QW   = W + 3;
  localparam int RW   = W + 5;
  localparam int DL   = QW + 1;
  localparam int LAT  = cpt_lat(COORD_WIDTH);

  localparam int S1W = 9 * W + 9 * VEC;
  localparam int S2W = 6 * DW + S1W;
  localparam int S3W = DENW + 3 * W + 1;
  localparam int S4W = 3 * W + 4;

  localparam int unsigned VP_B [6] = '{3, 1, 1, 5, 5, 3};

  typedef enum logic [2:0] {
    RG_A, RG_B, RG_AB, RG_C, RG_AC, RG_BC, RG_IN
  } region_e;

  logic           accept;
  logic [LAT-1:0] vld_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // input capture
  logic [2:0][W-1:0] a_in_q, b_in_q, c_in_q, p_in_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_in_q <= {az_i, ay_i, ax_i};
      b_in_q <= {bz_i, by_coord_i, bx_i};
      c_in_q <= {cz_i, cy_i, cx_i};
      p_in_q <= {pz_i, py_i, px_i};
    end
  end

  // edge and offset vectors
  logic [2:0][W-1:0]   a_df_q, b_df_q, c_df_q;
  logic [2:0][VEC-1:0] ab_df_q, ac_df_q, ap_df_q, bp_df_q, cp_df_q, cb_df_q;

  always_ff @(posedge clk_i) begin
    a_df_q <= a_in_q;
    b_df_q <= b_in_q;
    c_df_q <= c_in_q;
    for (int k = 0; k < 3; k++) begin
      ab_df_q[k] <= VEC'($signed(b_in_q[k])) - VEC'($signed(a_in_q[k]));
      ac_df_q[k] <= VEC'($signed(c_in_q[k])) - VEC'($signed(a_in_q[k]));
      ap_df_q[k] <= VEC'($signed(p_in_q[k])) - VEC'($signed(a_in_q[k]));
      bp_df_q[k] <= VEC'($signed(p_in_q[k])) - VEC'($signed(b_in_q[k]));
      cp_df_q[k] <= VEC'($signed(p_in_q[k])) - VEC'($signed(c_in_q[k]));
      cb_df_q[k] <= VEC'($signed(c_in_q[k])) - VEC'($signed(b_in_q[k]));
    end
  end

  // dot product terms: d1 ab.ap, d2 ac.ap, d3 ab.bp, d4 ac.bp, d5 ab.cp, d6 ac.cp
  logic [PW-1:0] dprod [6][3];

  for (genvar j = 0; j < 6; j++) begin : g_dot
    localparam int JA = j % 2;
    localparam int JB = j / 2;
    for (genvar k = 0; k < 3; k++) begin : g_axis
      logic [VEC-1:0] opa, opb;
      assign opa = (JA == 0) ? ab_df_q[k] : ac_df_q[k];
      assign opb = (JB == 0) ? ap_df_q[k] : ((JB == 1) ? bp_df_q[k] : cp_df_q[k]);
      cpt_mul #(.AW(VEC), .BW(VEC)) u_mul_dot (
        .clk_i (clk_i),
        .a_i   (opa),
        .b_i   (opb),
        .p_o   (dprod[j][k])
      );
    end
  end

  logic [S1W-1:0]      side1;
  logic [2:0][W-1:0]   a_m1, b_m1, c_m1;
  logic [2:0][VEC-1:0] ab_m1, ac_m1, cb_m1;

  cpt_dly #(.WIDTH(S1W), .DEPTH(MUL_LAT)) u_dly_dot (
    .clk_i (clk_i),
    .d_i   ({a_df_q, b_df_q, c_df_q, ab_df_q, ac_df_q, cb_df_q}),
    .q_o   (side1)
  );
  assign {a_m1, b_m1, c_m1, ab_m1, ac_m1, cb_m1} = side1;

  logic [5:0][DW-1:0]  d_dt_q;
  logic [2:0][W-1:0]   a_dt_q, b_dt_q, c_dt_q;
  logic [2:0][VEC-1:0] ab_dt_q, ac_dt_q, cb_dt_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 6; j++) begin
      d_dt_q[j] <= DW'($signed(dprod[j][0])) + DW'($signed(dprod[j][1]))
                 + DW'($signed(dprod[j][2]));
    end
    a_dt_q  <= a_m1;
    b_dt_q  <= b_m1;
    c_dt_q  <= c_m1;
    ab_dt_q <= ab_m1;
    ac_dt_q <= ac_m1;
    cb_dt_q <= cb_m1;
  end

  // barycentric products: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  logic [2*DW-1:0] vprod [6];

  for (genvar i = 0; i < 6; i++) begin : g_bary
    localparam int IA = 2 * (i % 3);
    cpt_mul #(.AW(DW), .BW(DW)) u_mul_bary (
      .clk_i (clk_i),
      .a_i   (d_dt_q[IA]),
      .b_i   (d_dt_q[VP_B[i]]),
      .p_o   (vprod[i])
    );
  end

  logic [S2W-1:0]      side2;
  logic [5:0][DW-1:0]  d_m2;
  logic [2:0][W-1:0]   a_m2, b_m2, c_m2;
  logic [2:0][VEC-1:0] ab_m2, ac_m2, cb_m2;

  cpt_dly #(.WIDTH(S2W), .DEPTH(MUL_LAT)) u_dly_bary (
    .clk_i (clk_i),
    .d_i   ({d_dt_q, a_dt_q, b_dt_q, c_dt_q, ab_dt_q, ac_dt_q, cb_dt_q}),
    .q_o   (side2)
  );
  assign {d_m2, a_m2, b_m2, c_m2, ab_m2, ac_m2, cb_m2} = side2;

  // region classification
  logic signed [DW-1:0] d1, d2, d3, d4, d5, d6;
  logic signed [VW-1:0] va_d, vb_d, vc_d;
  logic signed [EW-1:0] e1_d, e2_d;
  region_e              rg_d;

  assign d1 = $signed(d_m2[0]);
  assign d2 = $signed(d_m2[1]);
  assign d3 = $signed(d_m2[2]);
  assign d4 = $signed(d_m2[3]);
  assign d5 = $signed(d_m2[4]);
  assign d6 = $signed(d_m2[5]);

  always_comb begin
    logic le_d1, le_d2, le_d3, le_d6, le_e1, le_e2, le_va, le_vb, le_vc;
    vc_d  = VW'($signed(vprod[0])) - VW'($signed(vprod[1]));
    vb_d  = VW'($signed(vprod[2])) - VW'($signed(vprod[3]));
    va_d  = VW'($signed(vprod[4])) - VW'($signed(vprod[5]));
    e1_d  = EW'(d4) - EW'(d3);
    e2_d  = EW'(d5) - EW'(d6);
    le_d1 = d1[DW-1] | (d1 == '0);
    le_d2 = d2[DW-1] | (d2 == '0);
    le_d3 = d3[DW-1] | (d3 == '0);
    le_d6 = d6[DW-1] | (d6 == '0);
    le_e1 = e1_d[EW-1] | (e1_d == '0);
    le_e2 = e2_d[EW-1] | (e2_d == '0);
    le_va = va_d[VW-1] | (va_d == '0);
    le_vb = vb_d[VW-1] | (vb_d == '0);
    le_vc = vc_d[VW-1] | (vc_d == '0);
    if (le_d1 && le_d2) begin
      rg_d = RG_A;
    end else if (!d3[DW-1] && le_e1) begin
      rg_d = RG_B;
    end else if (le_vc && !d1[DW-1] && le_d3) begin
      rg_d = RG_AB;
    end else if (!d6[DW-1] && le_e2) begin
      rg_d = RG_C;
    end else if (le_vb && !d2[DW-1] && le_d6) begin
      rg_d = RG_AC;
    end else if (le_va && !e1_d[EW-1] && !e2_d[EW-1]) begin
      rg_d = RG_BC;
    end else begin
      rg_d = RG_IN;
    end
  end

  region_e              rg_cl_q;
  logic signed [VW-1:0] va_cl_q, vb_cl_q, vc_cl_q;
  logic signed [EW-1:0] e1_cl_q, e2_cl_q;
  logic [5:0][DW-1:0]   d_cl_q;
  logic [2:0][W-1:0]    a_cl_q, b_cl_q, c_cl_q;
  logic [2:0][VEC-1:0]  ab_cl_q, ac_cl_q, cb_cl_q;

  always_ff @(posedge clk_i) begin
    rg_cl_q <= rg_d;
    va_cl_q <= va_d;
    vb_cl_q <= vb_d;
    vc_cl_q <= vc_d;
    e1_cl_q <= e1_d;
    e2_cl_q <= e2_d;
    d_cl_q  <= d_m2;
    a_cl_q  <= a_m2;
    b_cl_q  <= b_m2;
    c_cl_q  <= c_m2;
    ab_cl_q <= ab_m2;
    ac_cl_q <= ac_m2;
    cb_cl_q <= cb_m2;
  end

  // per region: result = base + (m1*u + m2*w) / den
  logic signed [VW-1:0]   m1_d, m2_d;
  logic [2:0][VEC-1:0]    u_d, w_d;
  logic signed [DENW-1:0] den_d;
  logic [2:0][W-1:0]      base_d;
  logic                   bnd_d;

  always_comb begin
    m1_d   = '0;
    m2_d   = '0;
    u_d    = ab_cl_q;
    w_d    = ac_cl_q;
    den_d  = '0;
    base_d = a_cl_q;
    bnd_d  = 1'b1;
    unique case (rg_cl_q)
      RG_A: begin
        base_d = a_cl_q;
      end
      RG_B: begin
        base_d = b_cl_q;
      end
      RG_C: begin
        base_d = c_cl_q;
      end
      RG_AB: begin
        m1_d  = VW'($signed(d_cl_q[0]));
        den_d = DENW'($signed(d_cl_q[0])) - DENW'($signed(d_cl_q[2]));
      end
      RG_AC: begin
        m1_d  = VW'($signed(d_cl_q[1]));
        u_d   = ac_cl_q;
        den_d = DENW'($signed(d_cl_q[1])) - DENW'($signed(d_cl_q[5]));
      end
      RG_BC: begin
        m1_d   = VW'(e1_cl_q);
        u_d    = cb_cl_q;
        base_d = b_cl_q;
        den_d  = DENW'(e1_cl_q) + DENW'(e2_cl_q);
      end
      RG_IN: begin
        m1_d  = vb_cl_q;
        m2_d  = vc_cl_q;
        den_d = DENW'(va_cl_q) + DENW'(vb_cl_q) + DENW'(vc_cl_q);
        bnd_d = 1'b0;
      end
      default: begin
        base_d = a_cl_q;
      end
    endcase
  end

  logic signed [VW-1:0]   m1_sl_q, m2_sl_q;
  logic [2:0][VEC-1:0]    u_sl_q, w_sl_q;
  logic [DENW-1:0]        den_sl_q;
  logic [2:0][W-1:0]      base_sl_q;
  logic                   bnd_sl_q;

  always_ff @(posedge clk_i) begin
    m1_sl_q   <= m1_d;
    m2_sl_q   <= m2_d;
    u_sl_q    <= u_d;
    w_sl_q    <= w_d;
    den_sl_q  <= den_d;
    base_sl_q <= base_d;
    bnd_sl_q  <= bnd_d;
  end

  logic [NPW-1:0] np1 [3];
  logic [NPW-1:0] np2 [3];

  for (genvar k = 0; k < 3; k++) begin : g_num
    cpt_mul #(.AW(VW), .BW(VEC)) u_mul_n1 (
      .clk_i (clk_i),
      .a_i   (m1_sl_q),
      .b_i   (u_sl_q[k]),
      .p_o   (np1[k])
    );
    cpt_mul #(.AW(VW), .BW(VEC)) u_mul_n2 (
      .clk_i (clk_i),
      .a_i   (m2_sl_q),
      .b_i   (w_sl_q[k]),
      .p_o   (np2[k])
    );
  end

  logic [S3W-1:0]    side3;
  logic [DENW-1:0]   den_m3;
  logic [2:0][W-1:0] base_m3;
  logic              bnd_m3;

  cpt_dly #(.WIDTH(S3W), .DEPTH(MUL_LAT)) u_dly_num (
    .clk_i (clk_i),
    .d_i   ({den_sl_q, base_sl_q, bnd_sl_q}),
    .q_o   (side3)
  );
  assign {den_m3, base_m3, bnd_m3} = side3;

  logic [2:0][NW-1:0] num_sm_q;
  logic [DENW-1:0]    den_sm_q;
  logic [2:0][W-1:0]  base_sm_q;
  logic               bnd_sm_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      num_sm_q[k] <= NW'($signed(np1[k])) + NW'($signed(np2[k]));
    end
    den_sm_q  <= den_m3;
    base_sm_q <= base_m3;
    bnd_sm_q  <= bnd_m3;
  end

  // magnitudes for the quotient unit, sign kept aside
  logic [2:0][NW-1:0] nmag_mg_q;
  logic [DENW-1:0]    dmag_mg_q;
  logic [2:0]         qneg_mg_q;
  logic [2:0][W-1:0]  base_mg_q;
  logic               bnd_mg_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      nmag_mg_q[k] <= num_sm_q[k][NW-1] ? (~num_sm_q[k] + NW'(1)) : num_sm_q[k];
      qneg_mg_q[k] <= num_sm_q[k][NW-1] ^ den_sm_q[DENW-1];
    end
    dmag_mg_q <= den_sm_q[DENW-1] ? (~den_sm_q + DENW'(1)) : den_sm_q;
    base_mg_q <= base_sm_q;
    bnd_mg_q  <= bnd_sm_q;
  end

  logic [QW-1:0] quo [3];
  logic [2:0]    ovf;

  for (genvar k = 0; k < 3; k++) begin : g_div
    cpt_div #(.NW(NW), .DW(DENW), .QW(QW)) u_div (
      .clk_i (clk_i),
      .n_i   (nmag_mg_q[k]),
      .d_i   (dmag_mg_q),
      .q_o   (quo[k]),
      .ovf_o (ovf[k])
    );
  end

  logic [S4W-1:0]    side4;
  logic [2:0][W-1:0] base_dv;
  logic              bnd_dv;
  logic [2:0]        qneg_dv;

  cpt_dly #(.WIDTH(S4W), .DEPTH(DL)) u_dly_div (
    .clk_i (clk_i),
    .d_i   ({base_mg_q, bnd_mg_q, qneg_mg_q}),
    .q_o   (side4)
  );
  assign {base_dv, bnd_dv, qneg_dv} = side4;

  // add to base point and clamp to the coordinate range
  logic [2:0][W-1:0] res_d;
  logic [W-1:0]      pos_max, neg_min;

  assign pos_max = {1'b0, {(W-1){1'b1}}};
  assign neg_min = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    logic [RW-1:0] mag, sq, sum;
    for (int k = 0; k < 3; k++) begin
      mag = RW'(quo[k]);
      sq  = qneg_dv[k] ? (~mag + RW'(1)) : mag;
      sum = RW'($signed(base_dv[k])) + sq;
      if (ovf[k]) begin
        res_d[k] = qneg_dv[k] ? neg_min : pos_max;
      end else if ((sum[RW-1:W-1] != '0) && (sum[RW-1:W-1] != '1)) begin
        res_d[k] = sum[RW-1] ? neg_min : pos_max;
      end else begin
        res_d[k] = sum[W-1:0];
      end
    end
  end

  logic [2:0][W-1:0] res_q;
  logic              bnd_q;

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    bnd_q <= bnd_dv;
  end

  assign done_o        = vld_q[LAT-1];
  assign rx_o          = res_q[0];
  assign ry_o          = res_q[1];
  assign rz_o          = res_q[2];
  assign on_boundary_o = bnd_q;

endmodule

// File: hw/rtl/cpt_dly.sv
module cpt_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] stage_q [DEPTH];

  always_ff @(posedge clk_i) begin
    stage_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      stage_q[i] <= stage_q[i-1];
    end
  end

  assign q_o = stage_q[DEPTH-1];

endmodule

// File: hw/rtl/cpt_mul.sv
module cpt_mul #(
  parameter int AW = 8,
  parameter int BW = 8
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int PW = AW + BW;
  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;

  logic [AW-1:0]    amag_q;
  logic [BW-1:0]    bmag_q;
  logic             neg1_q, neg2_q, neg3_q;
  logic [AH+BH-1:0] hh_q;
  logic [AH+BL-1:0] hl_q;
  logic [AL+BH-1:0] lh_q;
  logic [AL+BL-1:0] ll_q;
  logic [PW-1:0]    sum_q;
  logic [PW-1:0]    p_q;

  // magnitudes, then four half-width partial products, then sum, then sign
  always_ff @(posedge clk_i) begin
    amag_q <= a_i[AW-1] ? (~a_i + AW'(1)) : a_i;
    bmag_q <= b_i[BW-1] ? (~b_i + BW'(1)) : b_i;
    neg1_q <= a_i[AW-1] ^ b_i[BW-1];

    hh_q   <= amag_q[AW-1:AL] * bmag_q[BW-1:BL];
    hl_q   <= amag_q[AW-1:AL] * bmag_q[BL-1:0];
    lh_q   <= amag_q[AL-1:0] * bmag_q[BW-1:BL];
    ll_q   <= amag_q[AL-1:0] * bmag_q[BL-1:0];
    neg2_q <= neg1_q;

    sum_q  <= (PW'(hh_q) << (AL + BL)) + (PW'(hl_q) << AL) + (PW'(lh_q) << BL) + PW'(ll_q);
    neg3_q <= neg2_q;

    p_q    <= neg3_q ? (~sum_q + PW'(1)) : sum_q;
  end

  assign p_o = p_q;

endmodule

// File: hw/rtl/cpt_div.sv
module cpt_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 4
) (
  input  logic          clk_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o,
  output logic          ovf_o
);

  localparam int XW = NW + QW;

  logic [NW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];
  logic          dz_q  [QW+1];

  // quotient too large for QW bits is flagged up front
  always_ff @(posedge clk_i) begin
    rem_q[0] <= n_i;
    den_q[0] <= d_i;
    quo_q[0] <= '0;
    dz_q[0]  <= (d_i == '0);
    ovf_q[0] <= (d_i != '0) && (XW'(n_i) >= (XW'(d_i) << QW));
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int SH = QW - 1 - s;
    logic [XW-1:0] trial;
    logic          fit;

    assign trial = XW'(den_q[s]) << SH;
    assign fit   = XW'(rem_q[s]) >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= fit ? NW'(XW'(rem_q[s]) - trial) : rem_q[s];
      quo_q[s+1] <= quo_q[s] | (fit ? (QW'(1) << SH) : QW'(0));
      den_q[s+1] <= den_q[s];
      ovf_q[s+1] <= ovf_q[s];
      dz_q[s+1]  <= dz_q[s];
    end
  end

  // zero divisor gives a zero quotient
  assign q_o   = dz_q[QW] ? '0 : quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

// File: hw/rtl/cpt_chk.sv
module cpt_chk import cpt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic                   done_o,
  input logic [COORD_WIDTH-1:0] ax_i,
  input logic [COORD_WIDTH-1:0] ay_i,
  input logic [COORD_WIDTH-1:0] az_i,
  input logic [COORD_WIDTH-1:0] px_i,
  input logic [COORD_WIDTH-1:0] py_i,
  input logic [COORD_WIDTH-1:0] pz_i,
  input logic [COORD_WIDTH-1:0] rx_o,
  input logic [COORD_WIDTH-1:0] ry_o,
  input logic [COORD_WIDTH-1:0] rz_o,
  input logic                   on_boundary_o
);

  localparam int LAT = cpt_lat(COORD_WIDTH);

  // every transfer gives its result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("missing result after transfer");

  // no result without a transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without transfer");

  // query on vertex a returns vertex a on the boundary
  a_vertex_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && px_i == ax_i && py_i == ay_i && pz_i == az_i) |-> ##LAT
    (on_boundary_o && rx_o == $past(ax_i, LAT) && ry_o == $past(ay_i, LAT)
     && rz_o == $past(az_i, LAT)))
    else $error("query at vertex a not returned as vertex a");

endmodule

bind closest_point_on_triangle_core cpt_chk #(.COORD_WIDTH(COORD_WIDTH)) u_cpt_chk (.*);

// File: tb/closest_point_on_triangle_checker.sv
module closest_point_on_triangle_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [31:0] ax_i,
  input  logic [31:0] ay_i,
  input  logic [31:0] az_i,
  input  logic [31:0] bx_i,
  input  logic [31:0] by_coord_i,
  input  logic [31:0] bz_i,
  input  logic [31:0] cx_i,
  input  logic [31:0] cy_i,
  input  logic [31:0] cz_i,
  input  logic [31:0] px_i,
  input  logic [31:0] py_i,
  input  logic [31:0] pz_i,
  input  logic        done_i,
  input  logic [31:0] rx_i,
  input  logic [31:0] ry_i,
  input  logic [31:0] rz_i,
  input  logic        on_boundary_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          interior_count_o,
  output int          result_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic        on_boundary;
  } closest_t;

  closest_t expected_points[$];

  function automatic wide_t dot3(input wide_t u[3], input wide_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic wide_t quot(input wide_t n, input wide_t d);
    if (d == 0) return 0;
    return n / d;
  endfunction

  function automatic logic [31:0] clamp32(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = 2147483647;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[31:0];
  endfunction

  function automatic closest_t closest_point(input logic [31:0] in[12]);
    wide_t a[3], b[3], c[3], p[3], ab[3], ac[3], ap[3], bp[3], cp[3], cb[3], r[3];
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, den;
    closest_t res;
    for (int k = 0; k < 3; k++) begin
      a[k] = $signed(in[k]);
      b[k] = $signed(in[3 + k]);
      c[k] = $signed(in[6 + k]);
      p[k] = $signed(in[9 + k]);
    end
    for (int k = 0; k < 3; k++) begin
      ab[k] = b[k] - a[k];
      ac[k] = c[k] - a[k];
      ap[k] = p[k] - a[k];
      bp[k] = p[k] - b[k];
      cp[k] = p[k] - c[k];
      cb[k] = c[k] - b[k];
    end
    d1 = dot3(ab, ap);
    d2 = dot3(ac, ap);
    d3 = dot3(ab, bp);
    d4 = dot3(ac, bp);
    d5 = dot3(ab, cp);
    d6 = dot3(ac, cp);
    vc = d1 * d4 - d3 * d2;
    vb = d5 * d2 - d1 * d6;
    va = d3 * d6 - d5 * d4;
    e1 = d4 - d3;
    e2 = d5 - d6;
    res.on_boundary = 1'b1;
    if (d1 <= 0 && d2 <= 0) begin
      for (int k = 0; k < 3; k++) r[k] = a[k];
    end else if (d3 >= 0 && d4 - d3 <= 0) begin
      for (int k = 0; k < 3; k++) r[k] = b[k];
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      den = d1 - d3;
      for (int k = 0; k < 3; k++) r[k] = a[k] + quot(d1 * ab[k], den);
    end else if (d6 >= 0 && d5 - d6 <= 0) begin
      for (int k = 0; k < 3; k++) r[k] = c[k];
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      den = d2 - d6;
      for (int k = 0; k < 3; k++) r[k] = a[k] + quot(d2 * ac[k], den);
    end else if (va <= 0 && e1 >= 0 && e2 >= 0) begin
      den = e1 + e2;
      for (int k = 0; k < 3; k++) r[k] = b[k] + quot(e1 * cb[k], den);
    end else begin
      den = va + vb + vc;
      res.on_boundary = 1'b0;
      for (int k = 0; k < 3; k++) r[k] = a[k] + quot(vb * ab[k] + vc * ac[k], den);
    end
    res.rx = clamp32(r[0]);
    res.ry = clamp32(r[1]);
    res.rz = clamp32(r[2]);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] query[12];
    closest_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      interior_count_o <= 0;
      result_count_o <= 0;
    end else begin
      if (start_i && !busy_i) begin
        query = '{ax_i, ay_i, az_i, bx_i, by_coord_i, bz_i,
                  cx_i, cy_i, cz_i, px_i, py_i, pz_i};
        expected_points.push_back(closest_point(query));
      end
      if (done_i) begin
        result_count_o <= result_count_o + 1;
        if (expected_points.size() == 0) begin
          if (fail_count_o < 10) $display("error: result with no query outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_points.pop_front();
          if (!want.on_boundary) interior_count_o <= interior_count_o + 1;
          if (want.rx !== rx_i || want.ry !== ry_i || want.rz !== rz_i ||
              want.on_boundary !== on_boundary_i) begin
            if (fail_count_o < 10)
              $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                       want.rx, want.ry, want.rz, want.on_boundary,
                       rx_i, ry_i, rz_i, on_boundary_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
    pending_o = expected_points.size();
  end

endmodule

// File: tb/closest_point_on_triangle_core_test.sv
module closest_point_on_triangle_core_test import cpt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_QUERIES = 1100;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic [31:0] coord[12];
  logic done_o;
  logic [31:0] rx_o, ry_o, rz_o;
  logic on_boundary_o;
  int fail_count, pending, interior_count, result_count;
  int idle_cycles;
  int query_count;

  closest_point_on_triangle_core dut (
    .clk_i, .rst_ni, .start, .busy,
    .ax_i(coord[0]), .ay_i(coord[1]), .az_i(coord[2]),
    .bx_i(coord[3]), .by_coord_i(coord[4]), .bz_i(coord[5]),
    .cx_i(coord[6]), .cy_i(coord[7]), .cz_i(coord[8]),
    .px_i(coord[9]), .py_i(coord[10]), .pz_i(coord[11]),
    .done_o, .rx_o, .ry_o, .rz_o, .on_boundary_o
  );

  closest_point_on_triangle_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .ax_i(coord[0]), .ay_i(coord[1]), .az_i(coord[2]),
    .bx_i(coord[3]), .by_coord_i(coord[4]), .bz_i(coord[5]),
    .cx_i(coord[6]), .cy_i(coord[7]), .cz_i(coord[8]),
    .px_i(coord[9]), .py_i(coord[10]), .pz_i(coord[11]),
    .done_i(done_o), .rx_i(rx_o), .ry_i(ry_o), .rz_i(rz_o),
    .on_boundary_i(on_boundary_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .interior_count_o(interior_count), .result_count_o(result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] fix(input int v);
    return v <<< 16;
  endfunction

  // drive one query and hold it until the transfer happens
  task automatic send(input logic [31:0] q[12]);
    start <= 1'b1;
    for (int k = 0; k < 12; k++) coord[k] <= q[k];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    query_count++;
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_fixed(input int v[12]);
    logic [31:0] q[12];
    for (int k = 0; k < 12; k++) q[k] = fix(v[k]);
    send(q);
  endtask

  function automatic logic [31:0] rand_word(input int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  task automatic send_random();
    logic [31:0] q[12];
    int mode, sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      // wide noise, extremes mixed in
      for (int k = 0; k < 12; k++) q[k] = rand_word($urandom_range(0, 5) == 0 ? 1 : 0);
    end else if (sel < 4) begin
      for (int k = 0; k < 12; k++) q[k] = rand_word(2);
    end else if (sel == 4) begin
      // vertices that repeat coordinates: b from a or random, c from a or b, per axis
      for (int k = 0; k < 3; k++) begin
        q[k] = rand_word(2);
        q[3 + k] = $urandom_range(0, 1) ? q[k] : rand_word(2);
        q[6 + k] = $urandom_range(0, 1) ? q[k] : q[3 + k];
        q[9 + k] = rand_word(2);
      end
    end else begin
      // point placed near the triangle so every region is reached
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 9; k++) q[k] = rand_word(2);
      for (int k = 0; k < 3; k++) begin
        q[9 + k] = ($signed(q[k]) + $signed(q[3 + k]) + $signed(q[6 + k])) / 3
                   + ($signed($urandom_range(0, 32'h003f_ffff)) - 32'sh0020_0000)
                     / (mode + 1);
      end
    end
    send(q);
  endtask

  initial begin
    int burst;
    start = 1'b0;
    for (int k = 0; k < 12; k++) coord[k] = '0;
    query_count = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one region per query on a right triangle in the z=0 plane, then one general triangle
    send_fixed('{0, 0, 0, 10, 0, 0, 0, 10, 0, -1, -1, 0});
    send_fixed('{0, 0, 0, 10, 0, 0, 0, 10, 0, 12, -1, 0});
    send_fixed('{0, 0, 0, 10, 0, 0, 0, 10, 0, 5, -3, 2});
    send_fixed('{0, 0, 0, 10, 0, 0, 0, 10, 0, -1, 12, 0});
    send_fixed('{0, 0, 0, 10, 0, 0, 0, 10, 0, -3, 5, 1});
    send_fixed('{0, 0, 0, 10, 0, 0, 0, 10, 0, 6, 6, 3});
    send_fixed('{0, 0, 0, 10, 0, 0, 0, 10, 0, 2, 2, 5});
    send_fixed('{3, -7, 1, 9, 2, -4, -5, 6, 8, 1, 1, 1});
    // degenerate triangles, zero divisors
    send_fixed('{1, 2, 3, 1, 2, 3, 1, 2, 3, 7, -8, 9});
    send_fixed('{0, 0, 0, 4, 4, 4, 8, 8, 8, 5, 1, 3});
    send_fixed('{0, 0, 0, 4, 4, 4, 0, 0, 0, 2, 9, 2});
    pause(3);
    send('{default: 32'h0000_0000});
    send('{default: 32'h7fff_ffff});
    send('{default: 32'h8000_0000});
    send('{default: 32'hffff_ffff});
    send('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
           32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
           32'h7fff_ffff, 32'h8000_0000});
    send('{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
           32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff});
    send('{32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h8000_0000,
           32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678, 32'hedcb_a987,
           32'h0});

    // let the pipeline drain completely once
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    for (int n = 0; n < RANDOM_QUERIES; ) begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 16);
      for (int i = 0; i < burst && n < RANDOM_QUERIES; i++, n++) send_random();
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 30));
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (cpt_lat(32) + 10) @(posedge clk_i);

    $display("%0d queries sent, %0d results checked, %0d in the interior",
             query_count, result_count, interior_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_dly.sv
hw/rtl/cpt_mul.sv
hw/rtl/cpt_div.sv
hw/rtl/closest_point_on_triangle_core.sv
hw/rtl/cpt_chk.sv
tb/closest_point_on_triangle_checker.sv
tb/closest_point_on_triangle_core_test.sv
